[rtl/prq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg: shared types for the priority ready queue
// Command and status codes, controller states and the command/status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package prq_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_PICK   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_CHANGE = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_FULL       = 2'd1,
		STS_NOT_QUEUED = 2'd2,
		STS_DUP        = 2'd3
	} sts_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FWD,
		ST_INS_INIT,
		ST_INS,
		ST_INS_HEAD,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic      accept;       // latch the incoming item
		logic      fwd_init;     // set up a forward pass from the head
		logic      fwd_run;      // forward pass: search, then close the gap
		logic      ins_init;     // set up a backward pass from the tail
		logic      ins_run;      // backward pass: shift up until the slot is found
		logic      head_write;   // new entry goes to the head slot
		logic      cnt_inc;
		logic      cnt_dec;
		logic      set_sts;
		sts_code_t sts;
		logic      clear_chosen; // pick on an empty queue
		logic      load_out;     // move the result into the output register
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		cmd_code_t cmd;
		logic      cnt_zero;
		logic      full;
		logic      fwd_last;     // last entry of the forward pass is being handled
		logic      found;
		logic      ins_end;      // backward pass is over this cycle
		logic      ins_stopped;  // ... because the slot was found
		logic      out_free;
	} dp_stat_t;

endpackage

[rtl/prq_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_ctrl: sequencer of the priority ready queue
// Decodes the latched command and steps the datapath through its passes.
// ----------------------------------------------------------------------------
module prq_ctrl import prq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd_stall = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) state_d = ST_FINISH;
						else if (stat.cnt_zero) state_d = ST_INS_INIT;
						else state_d = ST_FWD;
					end
					default: begin
						if (stat.cnt_zero) state_d = ST_FINISH;
						else state_d = ST_FWD;
					end
				endcase
			end
			ST_FWD: begin
				if (stat.fwd_last) begin
					if (stat.found && (stat.cmd == CMD_CHANGE)) state_d = ST_INS_INIT;
					else if (!stat.found && (stat.cmd == CMD_INSERT)) state_d = ST_INS_INIT;
					else state_d = ST_FINISH;
				end
			end
			ST_INS_INIT: begin
				if (stat.cnt_zero) state_d = ST_INS_HEAD;
				else state_d = ST_INS;
			end
			ST_INS: begin
				if (stat.ins_end) begin
					if (stat.ins_stopped) state_d = ST_FINISH;
					else state_d = ST_INS_HEAD;
				end
			end
			ST_INS_HEAD: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		ctl     = '0;
		ctl.sts = STS_OK;
		unique case (state_q)
			ST_IDLE: begin
				ctl.accept = cmd_valid;
			end
			ST_DECODE: begin
				ctl.fwd_init = 1'b1;
				unique case (stat.cmd)
					CMD_INSERT: begin
						if (stat.full) begin
							ctl.set_sts = 1'b1;
							ctl.sts     = STS_FULL;
						end
					end
					CMD_PICK: begin
						ctl.clear_chosen = stat.cnt_zero;
					end
					default: begin
						if (stat.cnt_zero) begin
							ctl.set_sts = 1'b1;
							ctl.sts     = STS_NOT_QUEUED;
						end
					end
				endcase
			end
			ST_FWD: begin
				ctl.fwd_run = 1'b1;
				if (stat.fwd_last) begin
					unique case (stat.cmd)
						CMD_INSERT: begin
							if (stat.found) begin
								ctl.set_sts = 1'b1;
								ctl.sts     = STS_DUP;
							end
						end
						CMD_PICK: begin
							ctl.cnt_dec = 1'b1;
						end
						default: begin
							if (stat.found) begin
								ctl.cnt_dec = 1'b1;
							end else begin
								ctl.set_sts = 1'b1;
								ctl.sts     = STS_NOT_QUEUED;
							end
						end
					endcase
				end
			end
			ST_INS_INIT: begin
				ctl.ins_init = 1'b1;
			end
			ST_INS: begin
				ctl.ins_run = 1'b1;
				ctl.cnt_inc = stat.ins_end && stat.ins_stopped;
			end
			ST_INS_HEAD: begin
				ctl.head_write = 1'b1;
			end
			ST_FINISH: begin
				ctl.load_out = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

[rtl/prq_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_datapath: queue storage and scan logic
// Ordered entry memory with one registered read and one write port, the
// scan pointers, the entry count, the head priority copy and the result
// register.
// ----------------------------------------------------------------------------
module prq_datapath import prq_pkg::*; #(
	parameter int MAX_QUEUED = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  ctl_cmd_t   ctl,
	output dp_stat_t   stat,
	input  logic [1:0] command,
	input  logic [3:0] task_id,
	input  logic [7:0] priority_req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [3:0] chosen_task,
	output logic [1:0] status,
	output logic [7:0] head_priority,
	output logic       queue_empty,
	output logic [4:0] queued_count
);

	localparam int AW = $clog2(MAX_QUEUED);
	localparam int CW = $clog2(MAX_QUEUED + 1);
	localparam logic [PRIO_WIDTH-1:0] PRIO_ALL_ONES = '1;

	// entry storage, index 0 is the head
	logic [3:0]            mem_task [MAX_QUEUED];
	logic [PRIO_WIDTH-1:0] mem_prio [MAX_QUEUED];

	cmd_code_t             cmd_q;
	logic [3:0]            id_q;
	logic [PRIO_WIDTH-1:0] prio_q;
	logic [CW-1:0]         count_q;
	logic [PRIO_WIDTH-1:0] head_q;
	logic [AW-1:0]         rd_ptr_q;
	logic [CW-1:0]         remain_q;
	logic                  found_q;
	logic [3:0]            chosen_q;
	sts_code_t             sts_q;

	logic                  vld_s1;
	logic [AW-1:0]         idx_s1;
	logic [3:0]            rtask_s1;
	logic [PRIO_WIDTH-1:0] rprio_s1;

	logic                  out_valid_q;
	logic [3:0]            out_task_q;
	sts_code_t             out_sts_q;
	logic [7:0]            out_head_q;
	logic                  out_empty_q;
	logic [4:0]            out_count_q;

	logic                  rd_go;
	logic                  proc_fwd, proc_ins;
	logic                  match_now, stop_now;
	logic [AW-1:0]         last_idx;
	logic                  shift_we, ins_we, we;
	logic [AW-1:0]         wr_addr;
	logic [3:0]            wr_task;
	logic [PRIO_WIDTH-1:0] wr_prio;

	assign last_idx = AW'(count_q - CW'(1));
	assign rd_go    = (ctl.fwd_run || ctl.ins_run) && (remain_q != '0);

	// forward pass: find the entry, then (but for an insert) move every later entry down one slot
	assign proc_fwd  = ctl.fwd_run && vld_s1;
	assign match_now = (cmd_q == CMD_PICK) ? (idx_s1 == '0) : (rtask_s1 == id_q);
	assign shift_we  = proc_fwd && found_q && (cmd_q != CMD_INSERT);

	// backward pass: move entries up one slot until one is not less urgent
	assign proc_ins = ctl.ins_run && vld_s1;
	assign stop_now = proc_ins && (rprio_s1 <= prio_q);
	assign ins_we   = proc_ins;

	assign we = shift_we || ins_we || ctl.head_write;

	always_comb begin
		wr_addr = '0;
		wr_task = id_q;
		wr_prio = prio_q;
		priority if (shift_we) begin
			wr_addr = AW'(idx_s1 - AW'(1));
			wr_task = rtask_s1;
			wr_prio = rprio_s1;
		end else if (ins_we) begin
			wr_addr = AW'(idx_s1 + AW'(1));
			if (!stop_now) begin
				wr_task = rtask_s1;
				wr_prio = rprio_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_task[wr_addr] <= wr_task;
			mem_prio[wr_addr] <= wr_prio;
		end
		if (rd_go) begin
			rtask_s1 <= mem_task[rd_ptr_q];
			rprio_s1 <= mem_prio[rd_ptr_q];
			idx_s1   <= rd_ptr_q;
		end
	end

	// scan pointers and item fields
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= cmd_code_t'(command);
			id_q     <= task_id;
			prio_q   <= PRIO_WIDTH'(priority_req);
			chosen_q <= task_id;
			sts_q    <= STS_OK;
		end else begin
			if (ctl.set_sts) sts_q <= ctl.sts;
			if (ctl.clear_chosen) chosen_q <= '0;
			if (proc_fwd && match_now && !found_q && (cmd_q == CMD_PICK)) begin
				chosen_q <= rtask_s1;
			end
		end
		if (ctl.fwd_init) begin
			rd_ptr_q <= '0;
			remain_q <= count_q;
		end else if (ctl.ins_init) begin
			rd_ptr_q <= last_idx;
			remain_q <= count_q;
		end else if (rd_go) begin
			rd_ptr_q <= ctl.fwd_run ? AW'(rd_ptr_q + AW'(1)) : AW'(rd_ptr_q - AW'(1));
			remain_q <= CW'(remain_q - CW'(1));
		end
		if (we && (wr_addr == '0)) head_q <= wr_prio;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= rd_go;
			if (ctl.fwd_init) found_q <= 1'b0;
			else if (proc_fwd && match_now) found_q <= 1'b1;
			if (ctl.cnt_dec) count_q <= CW'(count_q - CW'(1));
			else if (ctl.cnt_inc || ctl.head_write) count_q <= CW'(count_q + CW'(1));
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_task_q  <= chosen_q;
			out_sts_q   <= sts_q;
			out_head_q  <= (count_q == '0) ? 8'(PRIO_ALL_ONES) : 8'(head_q);
			out_empty_q <= (count_q == '0);
			out_count_q <= 5'(count_q);
		end
	end

	assign rsp_valid     = out_valid_q;
	assign chosen_task   = out_task_q;
	assign status        = out_sts_q;
	assign head_priority = out_head_q;
	assign queue_empty   = out_empty_q;
	assign queued_count  = out_count_q;

	always_comb begin
		stat.cmd         = cmd_q;
		stat.cnt_zero    = (count_q == '0);
		stat.full        = (count_q >= CW'(MAX_QUEUED));
		stat.fwd_last    = proc_fwd && (idx_s1 == last_idx);
		stat.found       = found_q || (proc_fwd && match_now);
		stat.ins_end     = proc_ins && (stop_now || (idx_s1 == '0));
		stat.ins_stopped = stop_now;
		stat.out_free    = !out_valid_q || !rsp_stall;
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_QUEUED))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1 |=> (count_q == $past(count_q)) || (count_q == CW'($past(count_q) + CW'(1)))
			|| (count_q == CW'($past(count_q) - CW'(1))))
		else $error("entry count moved by more than one");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(ins_we || ctl.head_write) |-> (count_q < CW'(MAX_QUEUED)))
		else $error("insert write into a full queue");

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> (out_empty_q == (out_count_q == '0)))
		else $error("empty flag disagrees with count");

endmodule

[rtl/priority_ready_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_ready_queue: scheduler ready queue ordered by priority
// Keeps queued task ids sorted by priority, first in first out within a level,
// and serves insert, pick, remove and priority change commands.
// ----------------------------------------------------------------------------
// One command item is taken at a time; cmd_stall is low only while the block
// waits for a new item. A pick or remove walks the queued entries once, and
// an insert or priority change may walk them twice; commands that fail on
// an empty or full queue walk none at all. The pace is set by the single
// read port of the entry memory: one entry is visited per cycle, once
// forward from the head to find a task and close the gap it leaves, and once
// backward from the tail to open the slot for an inserted task. The result
// sits in an output register, so the next command is taken while it waits on
// rsp_stall. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module priority_ready_queue import prq_pkg::*; #(
	parameter int MAX_QUEUED = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	// command channel
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] command,
	input  logic [3:0] task_id,
	input  logic [7:0] priority_req,
	// result channel
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [3:0] chosen_task,
	output logic [1:0] status,
	output logic [7:0] head_priority,
	output logic       queue_empty,
	output logic [4:0] queued_count
);

	ctl_cmd_t ctl;
	dp_stat_t stat;

	// sequencer: decodes each item and runs the scan passes
	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.stat      (stat),
		.ctl       (ctl)
	);

	// storage, scan pointers, count and the result register
	prq_datapath #(
		.MAX_QUEUED (MAX_QUEUED),
		.PRIO_WIDTH (PRIO_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.command       (command),
		.task_id       (task_id),
		.priority_req  (priority_req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.chosen_task   (chosen_task),
		.status        (status),
		.head_priority (head_priority),
		.queue_empty   (queue_empty),
		.queued_count  (queued_count)
	);

endmodule
